/* rtl/stl_pkg.sv */
// Shared types, character constants and helper functions for the source tokenizer.
// No dependencies; used by stl_lexer, stl_resq and source_tokenizer.
package stl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_INTEGER = 3'd4,
    MODE_IDENT   = 3'd5,
    MODE_HALT    = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    TOK_STRING  = 3'd0,
    TOK_INTEGER = 3'd1,
    TOK_PUNCT   = 3'd2,
    TOK_OPER    = 3'd3,
    TOK_IDENT   = 3'd4,
    TOK_ERROR   = 3'd5
  } tok_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_UPPER_B = 8'h42;
  localparam logic [7:0] CH_AT      = 8'h40;

  localparam int unsigned ACC_W = 31;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam int unsigned RESQ_DEPTH = 4;

  typedef struct packed {
    tok_t             tok_type;
    logic             has_char;
    logic [7:0]       char_out;
    logic             tok_first;
    logic             tok_last;
    logic [ACC_W-1:0] int_value;
    logic             overflowed;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    return c[7] || (c <= CH_SPACE);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == 8'h28) || (c == 8'h29) || (c == 8'h7b) || (c == 8'h7d) ||
           (c == 8'h3b) || (c == CH_AT) || (c == 8'h2c);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) || (c == 8'h3d);
  endfunction

  function automatic res_t make_res(input tok_t t, input logic has, input logic [7:0] ch,
                                    input logic first, input logic lst,
                                    input logic [ACC_W-1:0] val, input logic ovf);
    res_t r;
    r.tok_type   = t;
    r.has_char   = has;
    r.char_out   = ch;
    r.tok_first  = first;
    r.tok_last   = lst;
    r.int_value  = val;
    r.overflowed = ovf;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/source_tokenizer.sv */
// Top level of the source tokenizer: byte stream in, token results out.
// Depends on stl_pkg, stl_lexer and stl_resq.
//
//   channel | direction | payload
//   in_     | request   | tdata[7:0] source byte
//   out_    | result    | tdata token content/value, tuser kind, tlast last of the byte
//
// One byte is taken per cycle when the result queue has room for two entries.
// A byte that gives two results fills two queue entries, so a run of such bytes
// is held back by the output; all others run at one per cycle while the output is not stalled.
// Results are written into a four-entry queue when their byte is taken and leave
// from it in order; a stalled output blocks input once three entries are waiting.
// Synchronous active-low reset empties the queue.
module source_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] char_out, [8] tok_first, [9] tok_last,
                                  // [40:10] int_value, [41] overflowed, [47:42] zero
  output logic [3:0]  out_tuser,  // [2:0] tok_type, [3] has_char
  output logic        out_tlast   // last result of the source byte
);

  stl_pkg::push_t push;
  stl_pkg::res_t  res;
  logic           room;
  logic           step;

  assign in_tready = room;
  assign step      = in_tvalid && room;

  stl_lexer u_lexer (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (in_tdata),
    .push_o (push)
  );

  stl_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .res_o   (res)
  );

  assign out_tdata = {6'b0, res.overflowed, res.int_value, res.tok_last, res.tok_first,
                      res.char_out};
  assign out_tuser = {res.has_char, res.tok_type};
  assign out_tlast = res.last;

endmodule

/* rtl/stl_lexer.sv */
// Scanner state and per-byte token logic: up to two results for each accepted byte.
// Depends on stl_pkg.
module stl_lexer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  output stl_pkg::push_t push_o
);

  stl_pkg::mode_t                 mode_r, mode_nxt;
  logic [stl_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic                           single_r, single_nxt;
  logic                           empty_r, empty_nxt;
  logic                           sat_r, sat_nxt;

  stl_pkg::mode_t                 s_mode;
  logic                           s_valid, s_str, s_ident, s_int;
  stl_pkg::res_t                  s_res;

  logic                           p_valid, use_start;
  stl_pkg::res_t                  p_res;
  logic [stl_pkg::ACC_W+3:0]      prod;
  logic [stl_pkg::ACC_W-1:0]      digit;

  assign digit = {{(stl_pkg::ACC_W-4){1'b0}}, byte_i[3:0]};
  assign prod  = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {4'b0, digit};

  always_comb begin
    s_mode  = stl_pkg::MODE_IDLE;
    s_valid = 1'b0;
    s_str   = 1'b0;
    s_ident = 1'b0;
    s_int   = 1'b0;
    s_res   = '0;
    if (stl_pkg::is_space(byte_i)) begin
      s_mode = stl_pkg::MODE_IDLE;
    end else if (byte_i == stl_pkg::CH_SLASH) begin
      s_mode = stl_pkg::MODE_SLASH;
    end else if (byte_i == stl_pkg::CH_QUOTE) begin
      s_mode = stl_pkg::MODE_STRING;
      s_str  = 1'b1;
    end else if (stl_pkg::is_digit(byte_i)) begin
      s_mode = stl_pkg::MODE_INTEGER;
      s_int  = 1'b1;
    end else if (stl_pkg::is_punct(byte_i)) begin
      s_valid = 1'b1;
      s_res   = stl_pkg::make_res(stl_pkg::TOK_PUNCT, 1'b1, byte_i, 1'b1, 1'b1, '0, 1'b0);
    end else if (stl_pkg::is_oper(byte_i)) begin
      s_valid = 1'b1;
      s_res   = stl_pkg::make_res(stl_pkg::TOK_OPER, 1'b1, byte_i, 1'b1, 1'b1, '0, 1'b0);
    end else begin
      s_mode  = stl_pkg::MODE_IDENT;
      s_ident = 1'b1;
      s_valid = 1'b1;
      s_res   = stl_pkg::make_res(stl_pkg::TOK_IDENT, 1'b1, byte_i, 1'b1, 1'b0, '0, 1'b0);
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    single_nxt = single_r;
    empty_nxt  = empty_r;
    sat_nxt    = sat_r;
    p_valid    = 1'b0;
    p_res      = '0;
    use_start  = 1'b0;
    if (byte_i == stl_pkg::CH_NUL) begin
      unique case (mode_r)
        stl_pkg::MODE_SLASH: begin
          p_valid = 1'b1;
          p_res   = stl_pkg::make_res(stl_pkg::TOK_OPER, 1'b1, stl_pkg::CH_SLASH, 1'b1, 1'b1,
                                      '0, 1'b0);
        end
        stl_pkg::MODE_INTEGER: begin
          p_valid = 1'b1;
          p_res   = stl_pkg::make_res(stl_pkg::TOK_INTEGER, 1'b0, 8'h00, 1'b1, 1'b1, acc_r, sat_r);
        end
        stl_pkg::MODE_IDENT: begin
          p_valid = 1'b1;
          p_res   = stl_pkg::make_res(stl_pkg::TOK_IDENT, 1'b0, 8'h00, 1'b0, 1'b1, '0, 1'b0);
        end
        stl_pkg::MODE_STRING: begin
          p_valid = 1'b1;
          p_res   = stl_pkg::make_res(stl_pkg::TOK_ERROR, 1'b0, 8'h00, empty_r, 1'b1, '0, 1'b0);
        end
        default: begin
          p_valid = 1'b0;
        end
      endcase
      mode_nxt   = stl_pkg::MODE_IDLE;
      acc_nxt    = '0;
      single_nxt = 1'b0;
      empty_nxt  = 1'b1;
      sat_nxt    = 1'b0;
    end else begin
      unique case (mode_r)
        stl_pkg::MODE_SLASH: begin
          if (byte_i == stl_pkg::CH_SLASH) begin
            mode_nxt = stl_pkg::MODE_COMMENT;
          end else begin
            p_valid   = 1'b1;
            p_res     = stl_pkg::make_res(stl_pkg::TOK_OPER, 1'b1, stl_pkg::CH_SLASH, 1'b1, 1'b1,
                                          '0, 1'b0);
            use_start = 1'b1;
          end
        end
        stl_pkg::MODE_COMMENT: begin
          if (byte_i == stl_pkg::CH_NL) begin
            mode_nxt = stl_pkg::MODE_IDLE;
          end
        end
        stl_pkg::MODE_STRING: begin
          p_valid = 1'b1;
          if (byte_i == stl_pkg::CH_QUOTE) begin
            p_res     = stl_pkg::make_res(stl_pkg::TOK_STRING, 1'b0, 8'h00, empty_r, 1'b1,
                                          '0, 1'b0);
            empty_nxt = 1'b1;
            mode_nxt  = stl_pkg::MODE_IDLE;
          end else begin
            p_res     = stl_pkg::make_res(stl_pkg::TOK_STRING, 1'b1, byte_i, empty_r, 1'b0,
                                          '0, 1'b0);
            empty_nxt = 1'b0;
          end
        end
        stl_pkg::MODE_INTEGER: begin
          if (single_r && ((byte_i == stl_pkg::CH_LOWER_X) || (byte_i == stl_pkg::CH_UPPER_X) ||
                           (byte_i == stl_pkg::CH_LOWER_B) || (byte_i == stl_pkg::CH_UPPER_B))) begin
            p_valid    = 1'b1;
            p_res      = stl_pkg::make_res(stl_pkg::TOK_ERROR, 1'b0, 8'h00, 1'b1, 1'b1, '0, 1'b0);
            single_nxt = 1'b0;
            mode_nxt   = stl_pkg::MODE_HALT;
          end else if (stl_pkg::is_digit(byte_i)) begin
            if (prod > {4'b0, stl_pkg::ACC_MAX}) begin
              acc_nxt = stl_pkg::ACC_MAX;
              sat_nxt = 1'b1;
            end else begin
              acc_nxt = prod[stl_pkg::ACC_W-1:0];
            end
            single_nxt = 1'b0;
          end else begin
            p_valid    = 1'b1;
            p_res      = stl_pkg::make_res(stl_pkg::TOK_INTEGER, 1'b0, 8'h00, 1'b1, 1'b1,
                                           acc_r, sat_r);
            single_nxt = 1'b0;
            use_start  = 1'b1;
          end
        end
        stl_pkg::MODE_IDENT: begin
          p_valid = 1'b1;
          if (stl_pkg::is_space(byte_i) || stl_pkg::is_punct(byte_i)) begin
            p_res     = stl_pkg::make_res(stl_pkg::TOK_IDENT, 1'b0, 8'h00, 1'b0, 1'b1, '0, 1'b0);
            empty_nxt = 1'b1;
            use_start = 1'b1;
          end else begin
            p_res = stl_pkg::make_res(stl_pkg::TOK_IDENT, 1'b1, byte_i, 1'b0, 1'b0, '0, 1'b0);
          end
        end
        stl_pkg::MODE_HALT: begin
          p_valid = 1'b0;
        end
        default: begin
          use_start = 1'b1;
        end
      endcase
      if (use_start) begin
        mode_nxt = s_mode;
        if (s_str) begin
          empty_nxt = 1'b1;
        end
        if (s_ident) begin
          empty_nxt = 1'b0;
        end
        if (s_int) begin
          acc_nxt    = digit;
          single_nxt = 1'b1;
          sat_nxt    = 1'b0;
        end
      end
    end
  end

  always_comb begin
    push_o = '0;
    if (step_i) begin
      if (p_valid && use_start && s_valid) begin
        push_o.cnt       = 2'd2;
        push_o.res0      = p_res;
        push_o.res1      = s_res;
        push_o.res1.last = 1'b1;
      end else if (p_valid) begin
        push_o.cnt       = 2'd1;
        push_o.res0      = p_res;
        push_o.res0.last = 1'b1;
      end else if (use_start && s_valid) begin
        push_o.cnt       = 2'd1;
        push_o.res0      = s_res;
        push_o.res0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= stl_pkg::MODE_IDLE;
      acc_r    <= '0;
      single_r <= 1'b0;
      empty_r  <= 1'b1;
      sat_r    <= 1'b0;
    end else if (step_i) begin
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      single_r <= single_nxt;
      empty_r  <= empty_nxt;
      sat_r    <= sat_nxt;
    end
  end

endmodule

/* rtl/stl_resq.sv */
// Result queue: takes zero, one or two results per cycle, hands out one per cycle while ready_i is high.
// Depends on stl_pkg.
module stl_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  stl_pkg::push_t push_i,
  output logic          room_o,
  output logic          valid_o,
  input  logic          ready_i,
  output stl_pkg::res_t res_o
);

  localparam int unsigned PTR_W = $clog2(stl_pkg::RESQ_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  stl_pkg::res_t    mem_r [stl_pkg::RESQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign valid_o = (cnt_r != '0);
  assign res_o   = mem_r[rd_ptr_r];
  assign pop     = valid_o && ready_i;
  assign room_o  = (cnt_r <= CNT_W'(stl_pkg::RESQ_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_i.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push_i.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= push_i.res1;
    end
  end

endmodule
